>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
// Depends on nothing; each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VGD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vgd assertion failed");

// Next-cycle implication, disabled during reset.
`define VGD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vgd assertion failed");

`endif

>>> hw/rtl/vgd_pkg.sv
// Package for the voxel grid downsampler: sizes, codes, transaction types.
// Depends on nothing; used by every vgd_* module and the top level.
`default_nettype none

package vgd_pkg;

  localparam int CAPACITY    = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_SHIFT   = 2 * FRAC_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS   = 64;
  localparam int DSTEP_W     = $clog2(DIV_STEPS);

  localparam logic [31:0] INV_RESET = 32'(64'd1 << FRAC_BITS);
  localparam logic [63:0] MAG_LIMIT = 64'h0000_0000_8000_0000;

  typedef enum logic [1:0] {
    REG_INV_X = 2'd0,
    REG_INV_Y = 2'd1,
    REG_INV_Z = 2'd2,
    REG_AVG   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_DRAIN = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_DRD,
    ST_DCAP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } back_state_t;

  // One classified request, as queued between front and back.
  typedef struct packed {
    logic               req_type;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] kx;
    logic signed [31:0] ky;
    logic signed [31:0] kz;
  } job_t;

  // One table entry.
  typedef struct packed {
    logic signed [31:0] kx;
    logic signed [31:0] ky;
    logic signed [31:0] kz;
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic signed [63:0] sz;
    logic [31:0]        cnt;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic             overflow_flag;
    logic             busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Arithmetic shift of the exact product gives the floor.
  function automatic logic signed [31:0] key_of(input logic signed [63:0] prod);
    logic signed [63:0] q;
    q = prod >>> KEY_SHIFT;
    return sat32(q);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vgd_front.sv
// Front part: accepts requests, multiplies by the inverse leaf sizes, forms keys.
// Depends on vgd_pkg.
`default_nettype none

module vgd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                req_type,
  input  wire logic signed [31:0]  point_x,
  input  wire logic signed [31:0]  point_y,
  input  wire logic signed [31:0]  point_z,
  input  wire logic [31:0]         inv_x,
  input  wire logic [31:0]         inv_y,
  input  wire logic [31:0]         inv_z,
  output logic                     push,
  input  wire logic                push_ready,
  output vgd_pkg::job_t            push_job
);

  logic               a_valid;
  logic               a_req;
  logic signed [31:0] a_px, a_py, a_pz;
  logic               b_valid;
  logic               b_req;
  logic signed [31:0] b_px, b_py, b_pz;
  logic signed [63:0] prod_x, prod_y, prod_z;
  logic               b_free;
  logic               a_free;

  assign b_free   = !b_valid || push_ready;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;
  assign push     = b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= in_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) begin
      a_req <= req_type;
      a_px  <= point_x;
      a_py  <= point_y;
      a_pz  <= point_z;
    end
    if (b_free && a_valid) begin
      b_req  <= a_req;
      b_px   <= a_px;
      b_py   <= a_py;
      b_pz   <= a_pz;
      prod_x <= 64'(a_px * $signed({1'b0, inv_x}));
      prod_y <= 64'(a_py * $signed({1'b0, inv_y}));
      prod_z <= 64'(a_pz * $signed({1'b0, inv_z}));
    end
  end

  always_comb begin
    push_job.req_type = b_req;
    push_job.px       = b_px;
    push_job.py       = b_py;
    push_job.pz       = b_pz;
    push_job.kx       = vgd_pkg::key_of(prod_x);
    push_job.ky       = vgd_pkg::key_of(prod_y);
    push_job.kz       = vgd_pkg::key_of(prod_z);
  end

endmodule

`default_nettype wire

>>> hw/rtl/vgd_queue.sv
// Short request queue between the front and back parts.
// Depends on vgd_pkg.
`default_nettype none

module vgd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               push_ready,
  input  wire vgd_pkg::job_t push_job,
  output logic               pop_valid,
  input  wire logic          pop,
  output vgd_pkg::job_t      pop_job
);

  vgd_pkg::job_t                items [vgd_pkg::QUEUE_DEPTH];
  logic [vgd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [vgd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [vgd_pkg::QPTR_W:0]     fill;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = fill != (vgd_pkg::QPTR_W + 1)'(vgd_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = items[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      items[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vgd_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on vgd_pkg.
`default_nettype none

module vgd_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic                          busy;
  logic [vgd_pkg::DSTEP_W-1:0]   step;
  logic [31:0]                   rem;
  logic [63:0]                   quo;
  logic [31:0]                   dvs;
  logic [32:0]                   shifted;
  logic [32:0]                   diff;
  logic                          ge;

  assign shifted  = {rem, quo[63]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == vgd_pkg::DSTEP_W'(vgd_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      quo <= {quo[62:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vgd_back.sv
// Back part: voxel table, linear key search, update, drain with centroid divide in average mode.
// Depends on vgd_pkg and vgd_div.
`default_nettype none

module vgd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_valid,
  output logic                     pop,
  input  wire vgd_pkg::job_t       job,
  input  wire logic                average_mode,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic [31:0]              out_count,
  output logic                     out_valid,
  output logic                     out_last,
  output logic                     overflow,
  output vgd_pkg::status_t         status
);

  localparam int IW = vgd_pkg::IDX_W;
  localparam int CW = vgd_pkg::CNT_W;

  vgd_pkg::entry_t       mem [vgd_pkg::CAPACITY];
  vgd_pkg::entry_t       rdata;
  vgd_pkg::entry_t       wdata;
  logic [IW-1:0]         raddr;
  logic [IW-1:0]         waddr;
  logic                  we;

  vgd_pkg::back_state_t  state, state_next;
  vgd_pkg::job_t         job_r;
  vgd_pkg::entry_t       ent;
  logic [CW-1:0]         scan_idx;
  logic                  pend;
  logic [IW-1:0]         pend_idx;
  logic [IW-1:0]         hit_idx;
  logic [CW-1:0]         entry_count;
  logic [CW-1:0]         drain_index;
  logic                  overflow_flag;
  logic [1:0]            axis;

  logic                  match;
  logic                  hit;
  logic                  more;
  logic                  drain_empty;
  logic                  drain_ok;

  logic                  div_start;
  logic                  div_done;
  logic [63:0]           div_q;
  logic signed [63:0]    axis_sum;
  logic [63:0]           axis_mag;
  logic [31:0]           div_dvs;
  logic [63:0]           q_clamped;
  logic signed [63:0]    mean_wide;
  logic signed [31:0]    mean;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  vgd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (axis_mag),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign match = (rdata.kx == job_r.kx) && (rdata.ky == job_r.ky) && (rdata.kz == job_r.kz);
  assign hit   = pend && match;
  assign more  = scan_idx < entry_count;
  assign drain_empty = (entry_count == '0) || (drain_index >= entry_count);
  assign drain_ok    = job_valid && (job.req_type == vgd_pkg::REQ_DRAIN) && !res_valid;

  always_comb begin
    case (axis)
      2'd0:    axis_sum = ent.sx;
      2'd1:    axis_sum = ent.sy;
      default: axis_sum = ent.sz;
    endcase
  end

  assign axis_mag  = axis_sum[63] ? (64'd0 - 64'(axis_sum)) : 64'(axis_sum);
  assign div_dvs   = (ent.cnt == '0) ? 32'd1 : ent.cnt;
  assign q_clamped = (div_q > vgd_pkg::MAG_LIMIT) ? vgd_pkg::MAG_LIMIT : div_q;
  assign mean_wide = axis_sum[63] ? -$signed(q_clamped) : $signed(q_clamped);
  assign mean      = vgd_pkg::sat32(mean_wide);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = hit_idx;
    wdata      = ent;
    raddr      = scan_idx[IW-1:0];
    div_start  = 1'b0;
    case (state)
      vgd_pkg::ST_IDLE: begin
        if (job_valid && job.req_type == vgd_pkg::REQ_ADD) begin
          pop        = 1'b1;
          state_next = vgd_pkg::ST_SCAN;
        end else if (drain_ok) begin
          pop = 1'b1;
          if (!drain_empty) begin
            state_next = vgd_pkg::ST_DRD;
          end
        end
      end
      vgd_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = vgd_pkg::ST_UPD;
        end else if (!more) begin
          state_next = vgd_pkg::ST_IDLE;
          if (entry_count < CW'(vgd_pkg::CAPACITY)) begin
            we       = 1'b1;
            waddr    = entry_count[IW-1:0];
            wdata.kx = job_r.kx;
            wdata.ky = job_r.ky;
            wdata.kz = job_r.kz;
            wdata.sx = 64'(job_r.px);
            wdata.sy = 64'(job_r.py);
            wdata.sz = 64'(job_r.pz);
            wdata.cnt = 32'd1;
          end
        end
      end
      vgd_pkg::ST_UPD: begin
        state_next = vgd_pkg::ST_IDLE;
        if (ent.cnt != '1) begin
          we        = 1'b1;
          wdata.cnt = ent.cnt + 32'd1;
          if (average_mode) begin
            wdata.sx = ent.sx + 64'(job_r.px);
            wdata.sy = ent.sy + 64'(job_r.py);
            wdata.sz = ent.sz + 64'(job_r.pz);
          end
        end
      end
      vgd_pkg::ST_DRD: begin
        raddr      = drain_index[IW-1:0];
        state_next = vgd_pkg::ST_DCAP;
      end
      vgd_pkg::ST_DCAP: begin
        state_next = average_mode ? vgd_pkg::ST_DIV_GO : vgd_pkg::ST_EMIT;
      end
      vgd_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = vgd_pkg::ST_DIV_WAIT;
      end
      vgd_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (axis == 2'd2) ? vgd_pkg::ST_EMIT : vgd_pkg::ST_DIV_GO;
        end
      end
      vgd_pkg::ST_EMIT: begin
        state_next = vgd_pkg::ST_IDLE;
      end
      default: begin
        state_next = vgd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vgd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      drain_index   <= '0;
      overflow_flag <= 1'b0;
      res_valid     <= 1'b0;
      pend          <= 1'b0;
      scan_idx      <= '0;
      axis          <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        vgd_pkg::ST_IDLE: begin
          scan_idx <= '0;
          pend     <= 1'b0;
          if (!(job_valid && job.req_type == vgd_pkg::REQ_ADD) && drain_ok && drain_empty) begin
            res_valid   <= 1'b1;
            entry_count <= '0;
            drain_index <= '0;
          end
        end
        vgd_pkg::ST_SCAN: begin
          if (!hit && more) begin
            pend     <= 1'b1;
            scan_idx <= scan_idx + 1'b1;
          end else if (!hit) begin
            if (entry_count < CW'(vgd_pkg::CAPACITY)) begin
              entry_count <= entry_count + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
          end
        end
        vgd_pkg::ST_DCAP: begin
          axis <= '0;
        end
        vgd_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            axis <= axis + 1'b1;
          end
        end
        vgd_pkg::ST_EMIT: begin
          res_valid <= 1'b1;
          if (drain_index + 1'b1 >= entry_count) begin
            entry_count <= '0;
            drain_index <= '0;
          end else begin
            drain_index <= drain_index + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      vgd_pkg::ST_IDLE: begin
        if (pop) begin
          job_r <= job;
        end
        if (!(job_valid && job.req_type == vgd_pkg::REQ_ADD) && drain_ok && drain_empty) begin
          out_x     <= '0;
          out_y     <= '0;
          out_z     <= '0;
          out_count <= '0;
          out_valid <= 1'b0;
          out_last  <= 1'b0;
          overflow  <= overflow_flag;
        end
      end
      vgd_pkg::ST_SCAN: begin
        pend_idx <= scan_idx[IW-1:0];
        if (hit) begin
          ent     <= rdata;
          hit_idx <= pend_idx;
        end
      end
      vgd_pkg::ST_DCAP: begin
        ent   <= rdata;
        out_x <= vgd_pkg::sat32(rdata.sx);
        out_y <= vgd_pkg::sat32(rdata.sy);
        out_z <= vgd_pkg::sat32(rdata.sz);
      end
      vgd_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          case (axis)
            2'd0:    out_x <= mean;
            2'd1:    out_y <= mean;
            default: out_z <= mean;
          endcase
        end
      end
      vgd_pkg::ST_EMIT: begin
        out_count <= ent.cnt;
        out_valid <= 1'b1;
        out_last  <= (drain_index + 1'b1 >= entry_count);
        overflow  <= overflow_flag;
      end
      default: begin
      end
    endcase
  end

  assign status.entry_count   = entry_count;
  assign status.overflow_flag = overflow_flag;
  assign status.busy          = state != vgd_pkg::ST_IDLE;

endmodule

`default_nettype wire

>>> hw/rtl/voxel_grid_downsampler.sv
// Top level of the voxel grid downsampler: register file, front, queue, back.
// Depends on vgd_pkg, vgd_front, vgd_queue, vgd_back and assert_macros.svh.
//
// Usage. Requests enter on in_valid/in_ready: req_type 0 adds point_x/y/z
// (signed Q16.16), req_type 1 drains the next voxel. Each drain produces one
// result transaction on res_valid/res_ready; adds produce none. The APB port
// holds inv_leaf_x/y/z (0x0, 0x4, 0x8) and average_mode (0xC).
// Timing. The front registers each request in its capture and multiply stages
// and forms the voxel key; it accepts new requests while earlier ones are in
// flight unless the queue is full. A four-entry queue decouples it from the
// back part. The back's key search for an add reads the table memory one entry
// a cycle. In centroid mode a drain runs the shared one-bit-a-cycle divider
// once per axis.
// Reset clears the table (fill count to zero), the drain position and the
// sticky overflow flag, and loads the register reset values; the table memory
// itself is not cleared and needs no sweep. When the receiver stalls, the
// result is held in the output register; the back keeps executing adds, and
// only stops at the next drain until the held transaction is taken.
`default_nettype none
`include "assert_macros.svh"

module voxel_grid_downsampler (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               req_type,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [31:0]             out_count,
  output logic                    out_valid,
  output logic                    out_last,
  output logic                    overflow,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [31:0]       inv_leaf_x;
  logic [31:0]       inv_leaf_y;
  logic [31:0]       inv_leaf_z;
  logic              average_mode;
  logic              cfg_we;

  logic              q_push;
  logic              q_push_ready;
  vgd_pkg::job_t     q_push_job;
  logic              q_pop_valid;
  logic              q_pop;
  vgd_pkg::job_t     q_pop_job;
  vgd_pkg::status_t  status;

  // Register file: written in the access phase, zero wait states.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_leaf_x   <= vgd_pkg::INV_RESET;
      inv_leaf_y   <= vgd_pkg::INV_RESET;
      inv_leaf_z   <= vgd_pkg::INV_RESET;
      average_mode <= 1'b1;
    end else if (cfg_we) begin
      case (vgd_pkg::reg_idx_t'(paddr[3:2]))
        vgd_pkg::REG_INV_X: inv_leaf_x   <= pwdata;
        vgd_pkg::REG_INV_Y: inv_leaf_y   <= pwdata;
        vgd_pkg::REG_INV_Z: inv_leaf_z   <= pwdata;
        vgd_pkg::REG_AVG:   average_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (vgd_pkg::reg_idx_t'(paddr[3:2]))
      vgd_pkg::REG_INV_X: prdata = inv_leaf_x;
      vgd_pkg::REG_INV_Y: prdata = inv_leaf_y;
      vgd_pkg::REG_INV_Z: prdata = inv_leaf_z;
      vgd_pkg::REG_AVG:   prdata = {31'd0, average_mode};
      default:            prdata = '0;
    endcase
  end

  // Front: capture and key formation
  vgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .inv_x      (inv_leaf_x),
    .inv_y      (inv_leaf_y),
    .inv_z      (inv_leaf_z),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_job   (q_push_job)
  );

  // Queue: lets front and back stall independently
  vgd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_job    (q_pop_job)
  );

  // Back: table search, update and drain
  vgd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_pop_valid),
    .pop          (q_pop),
    .job          (q_pop_job),
    .average_mode (average_mode),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_count    (out_count),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .overflow     (overflow),
    .status       (status)
  );

  // Table fill never exceeds its capacity.
  `VGD_ASSERT_NOW(a_fill_bound, 1'b1, status.entry_count <= vgd_pkg::CNT_W'(vgd_pkg::CAPACITY))
  // A returned voxel always holds at least one point.
  `VGD_ASSERT_NOW(a_count_nonzero, res_valid && out_valid, out_count != '0)
  // Only a returned voxel can close a drain run.
  `VGD_ASSERT_NOW(a_last_valid, res_valid && out_last, out_valid)
  // Overflow is sticky until reset.
  `VGD_ASSERT_NEXT(a_ovf_sticky, status.overflow_flag, status.overflow_flag)

endmodule

`default_nettype wire
